>>> sv/cdq_pkg.sv
// Shared types and sizing constants for the circular double-ended queue.
// No dependencies; used by cdq_ctrl, cdq_dpath and circular_double_ended_queue.
`default_nettype none

package cdq_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int CMD_W  = 2;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 5;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_REAR  = 2'd0,
    CMD_PUSH_FRONT = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_REAR   = 2'd3
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RESP = 1'b1
  } state_e;

  typedef struct packed {
    logic    exec;
    logic    write;
    logic    read;
    logic    front;
    status_e code;
  } ctrl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } dp_stat_t;

endpackage

`default_nettype wire

>>> sv/cdq_ctrl.sv
// Controller for the circular double-ended queue: command decode and beat sequencing.
// Depends on cdq_pkg.
`default_nettype none

module cdq_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic [cdq_pkg::CMD_W-1:0] command_i,
  input  wire cdq_pkg::dp_stat_t   stat_i,
  output cdq_pkg::ctrl_t           ctrl_o,
  output logic                     busy_o,
  output logic                     done_o
);

  cdq_pkg::state_e state_q, state_d;
  cdq_pkg::cmd_e   cmd;

  assign cmd = cdq_pkg::cmd_e'(command_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cdq_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      cdq_pkg::ST_IDLE: begin
        if (start_i) begin
          state_d = cdq_pkg::ST_RESP;
        end
      end
      cdq_pkg::ST_RESP: begin
        state_d = cdq_pkg::ST_IDLE;
      end
      default: begin
        state_d = cdq_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctrl_o       = '0;
    ctrl_o.code  = cdq_pkg::STAT_DONE;
    busy_o       = 1'b0;
    done_o       = 1'b0;
    case (state_q)
      cdq_pkg::ST_IDLE: begin
        ctrl_o.exec = start_i;
        case (cmd)
          cdq_pkg::CMD_PUSH_REAR, cdq_pkg::CMD_PUSH_FRONT: begin
            ctrl_o.front = (cmd == cdq_pkg::CMD_PUSH_FRONT);
            if (stat_i.full) begin
              ctrl_o.code = cdq_pkg::STAT_FULL;
            end else begin
              ctrl_o.write = start_i;
            end
          end
          cdq_pkg::CMD_POP_FRONT, cdq_pkg::CMD_POP_REAR: begin
            ctrl_o.front = (cmd == cdq_pkg::CMD_POP_FRONT);
            if (stat_i.empty) begin
              ctrl_o.code = cdq_pkg::STAT_EMPTY;
            end else begin
              ctrl_o.read = start_i;
            end
          end
          default: begin
            ctrl_o.code = cdq_pkg::STAT_DONE;
          end
        endcase
      end
      cdq_pkg::ST_RESP: begin
        busy_o = 1'b1;
        done_o = 1'b1;
      end
      default: begin
        busy_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> sv/cdq_dpath.sv
// Datapath for the circular double-ended queue: slot memory, head/tail indices, count.
// Depends on cdq_pkg.
`default_nettype none

module cdq_dpath (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire cdq_pkg::ctrl_t              ctrl_i,
  input  wire logic signed [cdq_pkg::DATA_W-1:0] push_value_i,
  output cdq_pkg::dp_stat_t                stat_o,
  output logic [cdq_pkg::STAT_W-1:0]       status_o,
  output logic signed [cdq_pkg::DATA_W-1:0] popped_value_o,
  output logic [cdq_pkg::OCC_W-1:0]        occupancy_o
);

  localparam logic [cdq_pkg::IDX_W-1:0] IdxMax = cdq_pkg::IDX_W'(cdq_pkg::DEPTH - 1);
  localparam logic [cdq_pkg::CNT_W-1:0] CntMax = cdq_pkg::CNT_W'(cdq_pkg::DEPTH);

  logic [cdq_pkg::DATA_W-1:0] mem_q [cdq_pkg::DEPTH];
  logic [cdq_pkg::DATA_W-1:0] rdata_q;
  logic [cdq_pkg::IDX_W-1:0]  head_q, head_d, tail_q, tail_d;
  logic [cdq_pkg::IDX_W-1:0]  head_inc, head_dec, tail_inc, tail_dec, addr;
  logic [cdq_pkg::CNT_W-1:0]  count_q, count_d;
  cdq_pkg::status_e           status_q;
  logic                       pop_ok_q;
  logic [cdq_pkg::CNT_W+cdq_pkg::OCC_W-1:0] count_ext;

  assign head_inc = (head_q == IdxMax) ? '0 : head_q + 1'b1;
  assign head_dec = (head_q == '0) ? IdxMax : head_q - 1'b1;
  assign tail_inc = (tail_q == IdxMax) ? '0 : tail_q + 1'b1;
  assign tail_dec = (tail_q == '0) ? IdxMax : tail_q - 1'b1;

  assign stat_o.full  = (count_q == CntMax);
  assign stat_o.empty = (count_q == '0);

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    addr    = tail_q;
    if (ctrl_i.write) begin
      count_d = count_q + 1'b1;
      if (ctrl_i.front) begin
        head_d = head_dec;
        addr   = head_dec;
      end else begin
        tail_d = tail_inc;
        addr   = tail_q;
      end
    end else if (ctrl_i.read) begin
      count_d = count_q - 1'b1;
      if (ctrl_i.front) begin
        head_d = head_inc;
        addr   = head_q;
      end else begin
        tail_d = tail_dec;
        addr   = tail_dec;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      tail_q   <= '0;
      count_q  <= '0;
      status_q <= cdq_pkg::STAT_DONE;
      pop_ok_q <= 1'b0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      if (ctrl_i.exec) begin
        status_q <= ctrl_i.code;
        pop_ok_q <= ctrl_i.read;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.write) begin
      mem_q[addr] <= push_value_i;
    end
    if (ctrl_i.read) begin
      rdata_q <= mem_q[addr];
    end
  end

  assign count_ext      = {{cdq_pkg::OCC_W{1'b0}}, count_q};
  assign occupancy_o    = count_ext[cdq_pkg::OCC_W-1:0];
  assign status_o       = status_q;
  assign popped_value_o = pop_ok_q ? $signed(rdata_q) : '0;

endmodule

`default_nettype wire

>>> sv/circular_double_ended_queue.sv
// Circular double-ended queue of 32-bit signed words; top level.
// A command taken while idle gives its result strobe, done_o, in the next cycle.
// No new command is taken in the result cycle; busy is high in the result cycle,
// while the registered read of the slot memory is presented.
// Reset: asynchronous, active low; empties the queue, slot contents stay undefined.
// Depends on cdq_pkg, cdq_ctrl and cdq_dpath; results cannot be stalled.
`default_nettype none

module circular_double_ended_queue (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [cdq_pkg::CMD_W-1:0]          command_i,
  input  wire logic signed [cdq_pkg::DATA_W-1:0]  push_value_i,
  output logic                                    done_o,
  output logic [cdq_pkg::STAT_W-1:0]              status_o,
  output logic signed [cdq_pkg::DATA_W-1:0]       popped_value_o,
  output logic [cdq_pkg::OCC_W-1:0]               occupancy_o
);

  cdq_pkg::ctrl_t    ctrl;
  cdq_pkg::dp_stat_t stat;

  cdq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .command_i (command_i),
    .stat_i    (stat),
    .ctrl_o    (ctrl),
    .busy_o    (busy),
    .done_o    (done_o)
  );

  cdq_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .push_value_i   (push_value_i),
    .stat_o         (stat),
    .status_o       (status_o),
    .popped_value_o (popped_value_o),
    .occupancy_o    (occupancy_o)
  );

endmodule

`default_nettype wire
